// ===== hw/rtl/dna_consensus_column_counter_unit_defines.svh =====
// assertion macros shared by the consensus column counter rtl
// expects clk and rst to be visible in the module that uses them
`ifndef DNA_CONSENSUS_COLUMN_COUNTER_UNIT_DEFINES_SVH
`define DNA_CONSENSUS_COLUMN_COUNTER_UNIT_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define DCCU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define DCCU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dccu_pkg.sv =====
// shared types and constants for the consensus column counter
// no dependencies
`timescale 1ns / 1ps

package dccu_pkg;

  localparam int NUM_BASES = 4;
  localparam int ROW_W     = 11;
  localparam int COL_W     = 10;
  localparam int SYM_W     = 8;

  // ascii codes of A, C, G, T in tie-break order
  localparam logic [SYM_W-1:0] BASE_CODE [NUM_BASES] = '{8'd65, 8'd67, 8'd71, 8'd84};

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_READ = 1'b1
  } req_kind_t;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic [SYM_W-1:0] base;
    logic [ROW_W-1:0] mismatches;
  } result_t;

endpackage

// ===== hw/rtl/dccu_count_mem.sv =====
// single-port-write, single-port-read count store with registered read data
// a write to the address being read in the same cycle is forwarded to the read data
`timescale 1ns / 1ps

module dccu_count_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 44
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-modify-write of the same column on back to back requests
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// ===== hw/rtl/dccu_column_alu.sv =====
// update and consensus logic for one column entry
// uses dccu_pkg for base codes, request kinds and the result struct
`timescale 1ns / 1ps

module dccu_column_alu #(
  parameter int CB = 11
) (
  input  dccu_pkg::req_kind_t                     req,
  input  logic                                    in_store,
  input  logic [dccu_pkg::SYM_W-1:0]              symbol,
  input  logic [dccu_pkg::ROW_W-1:0]              row_count,
  input  logic [dccu_pkg::NUM_BASES*CB-1:0]       entry,
  output logic [dccu_pkg::NUM_BASES*CB-1:0]       new_entry,
  output logic                                    wr,
  output dccu_pkg::result_t                       result
);

  localparam int CMP_W = (CB > dccu_pkg::ROW_W) ? CB : dccu_pkg::ROW_W;

  logic [CB-1:0]    counts [dccu_pkg::NUM_BASES];
  logic [CB-1:0]    best;
  logic [1:0]       win;
  logic [CMP_W-1:0] row_ext;
  logic [CMP_W-1:0] best_ext;
  logic [CMP_W-1:0] miss;

  always_comb begin
    for (int k = 0; k < dccu_pkg::NUM_BASES; k++) begin
      counts[k] = in_store ? entry[k*CB +: CB] : '0;
    end

    // strict greater keeps the earliest base on ties
    best = counts[0];
    win  = 2'd0;
    for (int k = 1; k < dccu_pkg::NUM_BASES; k++) begin
      if (counts[k] > best) begin
        best = counts[k];
        win  = 2'(k);
      end
    end

    for (int k = 0; k < dccu_pkg::NUM_BASES; k++) begin
      if (req == dccu_pkg::REQ_READ) begin
        new_entry[k*CB +: CB] = '0;
      end else if ((symbol == dccu_pkg::BASE_CODE[k]) && (counts[k] != '1)) begin
        new_entry[k*CB +: CB] = counts[k] + CB'(1);
      end else begin
        new_entry[k*CB +: CB] = counts[k];
      end
    end

    wr = in_store;

    row_ext  = CMP_W'(row_count);
    best_ext = CMP_W'(best);
    miss     = (row_ext > best_ext) ? (row_ext - best_ext) : '0;

    result.base       = dccu_pkg::BASE_CODE[win];
    result.mismatches = miss[dccu_pkg::ROW_W-1:0];
  end

endmodule

// ===== hw/rtl/dna_consensus_column_counter_unit.sv =====
// consensus column counter: an accepted read passes the request stage, then the output register, to result valid
// throughput one request per cycle, any mix of adds and reads, same column back to back
// one read-modify-write of the count store per in-store request; stalls only when a read meets a full output
// reset is synchronous; afterwards the store is cleared one column per cycle
// through all MAX_COLUMNS columns, during which in_ready stays low (row_count writes still land)
`timescale 1ns / 1ps

`include "dna_consensus_column_counter_unit_defines.svh"

module dna_consensus_column_counter_unit #(
  parameter int MAX_COLUMNS = 1024,
  parameter int COUNT_BITS  = 11
) (
  input  logic                           clk,
  input  logic                           rst,
  // row count register
  input  logic                           cfg_wr_en,
  input  logic [dccu_pkg::ROW_W-1:0]     cfg_wr_data,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [0:0]                     req_type,
  input  logic [dccu_pkg::COL_W-1:0]     column,
  input  logic [dccu_pkg::SYM_W-1:0]     symbol,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dccu_pkg::SYM_W-1:0]     consensus_base,
  output logic [dccu_pkg::ROW_W-1:0]     column_mismatches
);

  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int DW = dccu_pkg::NUM_BASES * COUNT_BITS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_COLUMNS - 1);

  // control state
  dccu_pkg::ctrl_state_t state, state_next;
  logic [AW-1:0]         clr_addr;
  logic                  clr_last;

  logic [dccu_pkg::ROW_W-1:0] row_count;

  // request in flight: its entry is being read this cycle
  logic                        s1_valid;
  dccu_pkg::req_kind_t         s1_req;
  logic                        s1_in_store;
  logic [AW-1:0]               s1_addr;
  logic [dccu_pkg::SYM_W-1:0]  s1_symbol;
  logic                        s1_done;

  logic                        accept;
  logic                        out_free;
  logic                        in_store;

  // memory ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [DW-1:0] mem_rdata;

  // update logic
  logic [DW-1:0]      alu_entry;
  logic               alu_wr;
  dccu_pkg::result_t  alu_result;

  // columns past the store are treated as empty and never written
  assign in_store = (32'(column) < MAX_COLUMNS);
  assign clr_last = (clr_addr == LAST_ADDR);

  assign out_free = !out_valid || out_ready;
  // an add never waits; a read needs room in the output register
  assign s1_done  = s1_valid && ((s1_req == dccu_pkg::REQ_ADD) || out_free);
  assign in_ready = (state == dccu_pkg::ST_RUN) && (!s1_valid || s1_done);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dccu_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dccu_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_next = dccu_pkg::ST_RUN;
        end
      end
      dccu_pkg::ST_RUN: begin
        state_next = dccu_pkg::ST_RUN;
      end
      default: begin
        state_next = dccu_pkg::ST_CLEAR;
      end
    endcase
  end

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == dccu_pkg::ST_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
    end else if (cfg_wr_en) begin
      row_count <= cfg_wr_data;
    end
  end

  // request stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
  end

  // request stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req      <= dccu_pkg::req_kind_t'(req_type);
      s1_in_store <= in_store;
      s1_addr     <= AW'(column);
      s1_symbol   <= symbol;
    end
  end

  // write port: clearing sweep, else the finishing request's write back
  always_comb begin
    if (state == dccu_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_done && alu_wr;
      mem_waddr = s1_addr;
      mem_wdata = alu_entry;
    end
  end

  dccu_count_mem #(
    .DEPTH (MAX_COLUMNS),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (AW'(column)),
    .rd_data (mem_rdata),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata)
  );

  dccu_column_alu #(
    .CB (COUNT_BITS)
  ) u_alu (
    .req       (s1_req),
    .in_store  (s1_in_store),
    .symbol    (s1_symbol),
    .row_count (row_count),
    .entry     (mem_rdata),
    .new_entry (alu_entry),
    .wr        (alu_wr),
    .result    (alu_result)
  );

  // output register, one read result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_done && (s1_req == dccu_pkg::REQ_READ)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done && (s1_req == dccu_pkg::REQ_READ)) begin
      consensus_base    <= alu_result.base;
      column_mismatches <= alu_result.mismatches;
    end
  end

  `DCCU_ASSERT_NEXT(a_clear_ends, (state == dccu_pkg::ST_CLEAR) && clr_last,
    state == dccu_pkg::ST_RUN, "clearing sweep did not hand over to run")
  `DCCU_ASSERT_NOW(a_no_out_in_clear, state == dccu_pkg::ST_CLEAR,
    !out_valid && !s1_valid, "request activity during clearing sweep")
  `DCCU_ASSERT_NEXT(a_read_result, s1_done && (s1_req == dccu_pkg::REQ_READ),
    out_valid, "finished read request produced no result")
  `DCCU_ASSERT_NEXT(a_accept_tracked, accept, s1_valid,
    "accepted request not held in request stage")
  `DCCU_ASSERT_NOW(a_write_source, mem_we,
    (state == dccu_pkg::ST_CLEAR) || s1_done, "store written with no owner")

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for dna_consensus_column_counter_unit
// depends on dccu_pkg and the unit rtl; keeps its own column tally model
// adds and reads go through named test tasks under varied handshake pressure
`timescale 1ns / 1ps

module tb;

  localparam int COLUMNS        = 1024;
  localparam int TALLY_W        = 11;
  localparam int ROW_TOP        = 1024;
  localparam int WATCHDOG_LIMIT = 4000;
  // spare cycles after the last owed result, to cover adds still in flight
  localparam int SETTLE_CYCLES  = 4;

  localparam logic [TALLY_W-1:0]         TALLY_TOP = '1;
  localparam logic [dccu_pkg::SYM_W-1:0] SYM_A     = 8'h41;
  localparam logic [dccu_pkg::SYM_W-1:0] SYM_C     = 8'h43;
  localparam logic [dccu_pkg::SYM_W-1:0] SYM_G     = 8'h47;
  localparam logic [dccu_pkg::SYM_W-1:0] SYM_T     = 8'h54;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_wr_en;
  logic [dccu_pkg::ROW_W-1:0] cfg_wr_data;
  logic                       in_valid;
  logic                       in_ready;
  logic [0:0]                 req_type;
  logic [dccu_pkg::COL_W-1:0] column;
  logic [dccu_pkg::SYM_W-1:0] symbol;
  logic                       out_valid;
  logic                       out_ready;
  logic [dccu_pkg::SYM_W-1:0] consensus_base;
  logic [dccu_pkg::ROW_W-1:0] column_mismatches;

  // model of the count store and the row count register
  logic [TALLY_W-1:0]         tally [COLUMNS][dccu_pkg::NUM_BASES];
  logic [dccu_pkg::ROW_W-1:0] rows_now;
  // consensus results owed by the unit, oldest first
  dccu_pkg::result_t          pending_consensus[$];

  int fail_count;
  int quiet_cycles;
  int send_gap_pct;
  int recv_gap_pct;

  dna_consensus_column_counter_unit #(
    .MAX_COLUMNS(COLUMNS),
    .COUNT_BITS (TALLY_W)
  ) uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .req_type         (req_type),
    .column           (column),
    .symbol           (symbol),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .consensus_base   (consensus_base),
    .column_mismatches(column_mismatches)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // counter slot of a nucleotide, -1 for anything else (lowercase included)
  function automatic int base_slot(input logic [dccu_pkg::SYM_W-1:0] sym);
    case (sym)
      SYM_A:   return 0;
      SYM_C:   return 1;
      SYM_G:   return 2;
      SYM_T:   return 3;
      default: return -1;
    endcase
  endfunction

  // consensus of one column, then clear it; ties keep the earlier base
  function automatic dccu_pkg::result_t take_column(input logic [dccu_pkg::COL_W-1:0] col);
    dccu_pkg::result_t  r;
    int                 win;
    logic [TALLY_W-1:0] best;
    win  = 0;
    best = tally[col][0];
    for (int k = 1; k < dccu_pkg::NUM_BASES; k++) begin
      if (tally[col][k] > best) begin
        best = tally[col][k];
        win  = k;
      end
    end
    for (int k = 0; k < dccu_pkg::NUM_BASES; k++) tally[col][k] = '0;
    r.base       = dccu_pkg::BASE_CODE[win];
    // floored at zero when the winner outnumbers the rows
    r.mismatches = (rows_now > best) ? dccu_pkg::ROW_W'(rows_now - best) : '0;
    return r;
  endfunction

  // mostly nucleotides, now and then any byte
  function automatic logic [dccu_pkg::SYM_W-1:0] random_symbol();
    if ($urandom_range(0, 9) == 0) return dccu_pkg::SYM_W'($urandom_range(0, 255));
    return dccu_pkg::BASE_CODE[$urandom_range(0, dccu_pkg::NUM_BASES - 1)];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  // receiver stalls at the current rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
  end

  // tracks register writes and requests, and checks each result against the oldest owed one
  always @(posedge clk) begin
    dccu_pkg::result_t want;
    int                slot;
    if (!rst) begin
      if (cfg_wr_en) rows_now = cfg_wr_data;
      if (in_valid && in_ready) begin
        if (req_type == dccu_pkg::REQ_READ) begin
          pending_consensus.push_back(take_column(column));
        end else begin
          slot = base_slot(symbol);
          // a full counter holds its value
          if (slot >= 0 && tally[column][slot] != TALLY_TOP) tally[column][slot]++;
        end
      end
      if (out_valid && out_ready) begin
        if (pending_consensus.size() == 0) begin
          report_mismatch("result with nothing owed, base", consensus_base, 0);
        end else begin
          want = pending_consensus.pop_front();
          if (consensus_base !== want.base)
            report_mismatch("consensus base", consensus_base, want.base);
          if (column_mismatches !== want.mismatches)
            report_mismatch("column mismatches", column_mismatches, want.mismatches);
        end
      end
    end
  end

  // ends the run if nothing moves on either channel for too long
  // allows for the store clearing pass after reset
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // one request, held until accepted; valid stays up into the next call
  task automatic send_request(input dccu_pkg::req_kind_t kind,
                              input logic [dccu_pkg::COL_W-1:0] col,
                              input logic [dccu_pkg::SYM_W-1:0] sym);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    column   <= col;
    symbol   <= sym;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending and wait until every owed result is in
  task automatic drain_pending();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_consensus.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // row count change, only with the unit idle
  task automatic write_rows(input int value);
    drain_pending();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= dccu_pkg::ROW_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_gap_pct = sender_pct;
    recv_gap_pct = receiver_pct;
  endtask

  // untouched columns read as A; first read uses the reset row count of zero
  task automatic test_empty_columns();
    send_request(dccu_pkg::REQ_READ, 10'd0, 8'h00);
    send_request(dccu_pkg::REQ_READ, 10'd1023, 8'hff);
    write_rows(ROW_TOP);
    send_request(dccu_pkg::REQ_READ, 10'd512, 8'h55);
  endtask

  // every base wins once, a tie, counts above rows, and ignored symbols
  task automatic test_base_choice();
    write_rows(3);
    send_request(dccu_pkg::REQ_ADD, 10'd10, SYM_A);
    send_request(dccu_pkg::REQ_ADD, 10'd11, SYM_C);
    send_request(dccu_pkg::REQ_ADD, 10'd11, SYM_G);
    send_request(dccu_pkg::REQ_ADD, 10'd11, SYM_G);
    // four T in three rows: mismatches floor at zero
    repeat (4) send_request(dccu_pkg::REQ_ADD, 10'd12, SYM_T);
    // C and G tied, C comes first
    send_request(dccu_pkg::REQ_ADD, 10'd13, SYM_G);
    send_request(dccu_pkg::REQ_ADD, 10'd13, SYM_C);
    // lowercase and byte extremes leave the column empty
    send_request(dccu_pkg::REQ_ADD, 10'd14, 8'h61);
    send_request(dccu_pkg::REQ_ADD, 10'd14, 8'h74);
    send_request(dccu_pkg::REQ_ADD, 10'd14, 8'h00);
    send_request(dccu_pkg::REQ_ADD, 10'd14, 8'hff);
    for (int c = 10; c <= 14; c++)
      send_request(dccu_pkg::REQ_READ, dccu_pkg::COL_W'(c), 8'h00);
  endtask

  // top column with the row count at ROW_TOP, read then read cleared, then column 0 with one row fewer
  task automatic test_row_extremes();
    write_rows(ROW_TOP);
    repeat (3) send_request(dccu_pkg::REQ_ADD, 10'd1023, SYM_T);
    send_request(dccu_pkg::REQ_ADD, 10'd1023, SYM_A);
    send_request(dccu_pkg::REQ_READ, 10'd1023, 8'h00);
    send_request(dccu_pkg::REQ_READ, 10'd1023, 8'h00);
    write_rows(ROW_TOP - 1);
    send_request(dccu_pkg::REQ_READ, 10'd0, 8'hff);
  endtask

  // a small string set over a run of columns, then every column read back
  task automatic run_column_set(inout int done);
    int                         width;
    int                         depth;
    int                         start;
    int                         rows;
    logic [dccu_pkg::SYM_W-1:0] sym;
    width = $urandom_range(1, 8);
    depth = $urandom_range(1, 12);
    start = $urandom_range(0, COLUMNS - 1);
    case ($urandom_range(0, 3))
      0:       rows = $urandom_range(0, ROW_TOP);
      1:       rows = (depth > 2) ? depth - $urandom_range(0, 2) : depth + 1;
      default: rows = depth;
    endcase
    write_rows(rows);
    for (int r = 0; r < depth; r++) begin
      for (int c = 0; c < width; c++) begin
        sym = random_symbol();
        send_request(dccu_pkg::REQ_ADD, dccu_pkg::COL_W'(start + c), sym);
        done++;
      end
    end
    for (int c = 0; c < width; c++) begin
      send_request(dccu_pkg::REQ_READ, dccu_pkg::COL_W'(start + c),
                   dccu_pkg::SYM_W'($urandom_range(0, 255)));
      done++;
    end
  endtask

  // loose requests anywhere, some crowded onto the low columns
  task automatic run_noise(inout int done);
    dccu_pkg::req_kind_t        kind;
    logic [dccu_pkg::COL_W-1:0] col;
    logic [dccu_pkg::SYM_W-1:0] sym;
    repeat ($urandom_range(4, 16)) begin
      kind = $urandom_range(0, 1) ? dccu_pkg::REQ_READ : dccu_pkg::REQ_ADD;
      col  = $urandom_range(0, 1) ? dccu_pkg::COL_W'($urandom_range(0, COLUMNS - 1))
                                  : dccu_pkg::COL_W'($urandom_range(0, 15));
      sym  = $urandom_range(0, 1) ? dccu_pkg::SYM_W'($urandom_range(0, 255))
                                  : random_symbol();
      send_request(kind, col, sym);
      done++;
    end
  endtask

  task automatic test_random_traffic(input int quota);
    int done;
    done = 0;
    while (done < quota) begin
      if ($urandom_range(0, 3) != 0) run_column_set(done);
      else run_noise(done);
    end
  endtask

  initial begin
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    req_type    <= dccu_pkg::REQ_ADD;
    column      <= '0;
    symbol      <= '0;
    out_ready   <= 1'b0;
    fail_count   = 0;
    quiet_cycles = 0;
    rows_now     = '0;
    for (int c = 0; c < COLUMNS; c++) begin
      for (int k = 0; k < dccu_pkg::NUM_BASES; k++) tally[c][k] = '0;
    end
    set_idling(0, 0);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // sender idles a little, receiver a lot
    set_idling(27, 79);
    test_empty_columns();
    test_base_choice();
    test_row_extremes();
    test_random_traffic(540);
    // sender idles a lot, receiver a little
    set_idling(79, 27);
    test_random_traffic(540);
    // full rate both ways
    set_idling(0, 0);
    test_random_traffic(540);

    drain_pending();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
